// ===== sv/tbvc_pkg.sv =====
// shared types, constants and quantiser functions of the ternary block vote classifier
package tbvc_pkg;

	localparam int PIX_W      = 8;
	localparam int SIG_W      = 5;
	localparam int SIG_COUNT  = 27;
	localparam int SIG_BLANK  = 13;
	localparam int ACTION_W   = 2;
	localparam int BLOCK_W    = 15;
	localparam int KNOT_IN_W  = 9;
	localparam int LABEL_W    = 4;
	localparam int PRED_W     = 4;
	localparam int SCORE_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_DATA_W-1:0] LOW_THR_RESET  = 8'd85;
	localparam logic [CFG_DATA_W-1:0] HIGH_THR_RESET = 8'd170;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 2'd1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD     = 2'd0,
		ACT_TRAIN    = 2'd1,
		ACT_CLASSIFY = 2'd2
	} action_t;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_KNOT  = 7'b0000100,
		ST_MOD   = 7'b0001000,
		ST_SCAN0 = 7'b0010000,
		ST_SCAN  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

	typedef struct packed {
		logic add;
		logic start;
		logic clear;
	} vote_cmd_t;

	// ternary level plus one: 2 above high, 0 below low, else 1
	function automatic logic [1:0] trit_of(input logic [PIX_W-1:0] pix,
			input logic [PIX_W-1:0] lo, input logic [PIX_W-1:0] hi);
		logic [1:0] t;
		if (pix > hi) t = 2'd2;
		else if (pix < lo) t = 2'd0;
		else t = 2'd1;
		return t;
	endfunction

	// base-3 signature of three pixels, one of 27 values
	function automatic logic [SIG_W-1:0] sig_of(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c,
			input logic [PIX_W-1:0] lo, input logic [PIX_W-1:0] hi);
		logic [SIG_W-1:0] ta;
		logic [SIG_W-1:0] tb;
		logic [SIG_W-1:0] tc;
		ta = SIG_W'(trit_of(a, lo, hi));
		tb = SIG_W'(trit_of(b, lo, hi));
		tc = SIG_W'(trit_of(c, lo, hi));
		return SIG_W'(ta * 5'd9 + tb * 5'd3 + tc);
	endfunction

endpackage

// ===== sv/tbvc_knot_map.sv =====
// block to knot map, single-port synchronous memory
module tbvc_knot_ram #(
	parameter int DEPTH = 32768,
	parameter int KNOT_W = 9,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  tbvc_pkg::mem_cmd_t cmd,
	input  logic [AW-1:0]      addr,
	input  logic [KNOT_W-1:0]  wr_knot,
	output logic [KNOT_W-1:0]  rd_knot
);
	import tbvc_pkg::*;

	logic [KNOT_W-1:0] mem_q [DEPTH];
	logic [KNOT_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[addr] <= wr_knot;
		end
		if (cmd.rd) begin
			rd_q <= mem_q[addr];
		end
	end

	assign rd_knot = rd_q;

endmodule

// ===== sv/tbvc_count_mem.sv =====
// class count table, one row of all class counts per knot and signature, with clearing pass
module tbvc_count_mem #(
	parameter int ROWS = 13824,
	parameter int ROW_W = 320,
	localparam int AW = $clog2(ROWS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tbvc_pkg::mem_cmd_t cmd,
	input  logic [AW-1:0]      rd_addr,
	input  logic [AW-1:0]      wr_addr,
	input  logic [ROW_W-1:0]   wr_data,
	output logic [ROW_W-1:0]   rd_data,
	output logic               clr_busy
);
	import tbvc_pkg::*;

	logic [ROW_W-1:0] mem_q [ROWS];
	logic [ROW_W-1:0] rd_q;
	logic [AW-1:0]    clr_idx_q;
	logic             clr_busy_q;

	// sweep after reset, one row a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_idx_q == AW'(ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_idx_q] <= '0;
		end else if (cmd.wr) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data  = rd_q;
	assign clr_busy = clr_busy_q;

endmodule

// ===== sv/tbvc_vote.sv =====
// vote accumulators with a sequential argmax scan
module tbvc_vote #(
	parameter int CLASS_COUNT = 10,
	parameter int COUNT_BITS = 32,
	localparam int CLS_W = $clog2(CLASS_COUNT),
	localparam int ROW_W = CLASS_COUNT * COUNT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tbvc_pkg::vote_cmd_t cmd,
	input  logic [ROW_W-1:0]    row,
	output logic                done,
	output logic [CLS_W-1:0]    best_idx,
	output logic [COUNT_BITS-1:0] best_val
);
	import tbvc_pkg::*;

	logic [COUNT_BITS-1:0] acc_q [CLASS_COUNT];
	logic [CLS_W-1:0]      idx_q;
	logic                  busy_q;
	logic                  done_q;
	logic [CLS_W-1:0]      best_idx_q;
	logic [COUNT_BITS-1:0] best_val_q;
	logic [COUNT_BITS-1:0] cur;

	assign cur = acc_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CLASS_COUNT; c++) begin
				acc_q[c] <= '0;
			end
		end else if (cmd.clear) begin
			for (int c = 0; c < CLASS_COUNT; c++) begin
				acc_q[c] <= '0;
			end
		end else if (cmd.add) begin
			for (int c = 0; c < CLASS_COUNT; c++) begin
				acc_q[c] <= acc_q[c] + row[c*COUNT_BITS +: COUNT_BITS];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (cmd.start) begin
			idx_q  <= CLS_W'(1);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (idx_q == CLS_W'(CLASS_COUNT - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				idx_q <= idx_q + CLS_W'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// strict compare keeps the lowest class on ties
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_idx_q <= '0;
			best_val_q <= acc_q[0];
		end else if (busy_q && (cur > best_val_q)) begin
			best_idx_q <= idx_q;
			best_val_q <= cur;
		end
	end

	assign done     = done_q;
	assign best_idx = best_idx_q;
	assign best_val = best_val_q;

endmodule

// ===== sv/ternary_block_vote_classifier_unit.sv =====
// top level of the ternary block vote classifier: control, quantiser and output register
// one request at a time: a load is written on acceptance, a train or classify request walks
// the knot map read, the count row read, then the write-back or accumulate
// a classify request that ends an image shows its result once the argmax scan is done and
// the output register is free, the argmax walking one accumulator per cycle
// reset clears control, thresholds and accumulators, then a clearing pass zeroes the
// count table, all KNOT_COUNT * 27 rows (13824 at the default), before the first request
module ternary_block_vote_classifier_unit #(
	parameter int MAX_BLOCKS = 32768,
	parameter int KNOT_COUNT = 512,
	parameter int CLASS_COUNT = 10,
	parameter int COUNT_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tbvc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tbvc_pkg::CFG_DATA_W-1:0]   cfg_data,
	// request channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tbvc_pkg::ACTION_W-1:0]     action,
	input  logic [tbvc_pkg::BLOCK_W-1:0]      block_index,
	input  logic [tbvc_pkg::KNOT_IN_W-1:0]    knot_number,
	input  logic [tbvc_pkg::PIX_W-1:0]        pixel_a,
	input  logic [tbvc_pkg::PIX_W-1:0]        pixel_b,
	input  logic [tbvc_pkg::PIX_W-1:0]        pixel_c,
	input  logic [tbvc_pkg::LABEL_W-1:0]      class_label,
	input  logic                              last_block,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tbvc_pkg::PRED_W-1:0]       predicted_class,
	output logic [tbvc_pkg::SCORE_W-1:0]      best_score
);
	import tbvc_pkg::*;

	localparam int BLK_AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int KNOT_W = (KNOT_COUNT > 1) ? $clog2(KNOT_COUNT) : 1;
	localparam int ROWS   = KNOT_COUNT * SIG_COUNT;
	localparam int ROW_AW = $clog2(ROWS);
	localparam int ROW_W  = CLASS_COUNT * COUNT_BITS;
	localparam int CLS_W  = $clog2(CLASS_COUNT);

	// control state
	state_t state_q;
	state_t state_d;

	// threshold registers
	logic [PIX_W-1:0] low_thr_q;
	logic [PIX_W-1:0] high_thr_q;

	// captured request
	logic [ACTION_W-1:0] act_q;
	logic [SIG_W-1:0]    sig_q;
	logic [LABEL_W-1:0]  label_q;
	logic                last_q;
	logic                block_ok_q;
	logic                label_ok_q;
	logic [ROW_AW-1:0]   row_addr_q;

	// output register
	logic                  out_valid_q;
	logic [PRED_W-1:0]     pred_q;
	logic [SCORE_W-1:0]    score_q;

	// datapath
	logic                  in_acc;
	logic                  block_ok;
	logic                  knot_ok;
	logic                  label_ok;
	logic                  is_work;
	mem_cmd_t              knot_cmd;
	logic [KNOT_W-1:0]     knot_rd;
	logic [KNOT_W-1:0]     knot_sel;
	logic [ROW_AW-1:0]     row_addr;
	mem_cmd_t              cnt_cmd;
	logic [ROW_W-1:0]      row_rd;
	logic [ROW_W-1:0]      row_wr;
	logic                  clr_busy;
	vote_cmd_t             vote_cmd;
	logic                  scan_done;
	logic [CLS_W-1:0]      best_idx;
	logic [COUNT_BITS-1:0] best_val;
	logic                  emit_go;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;

	// range checks on the incoming request
	assign block_ok = (32'(block_index) < MAX_BLOCKS);
	assign knot_ok  = (32'(knot_number) < KNOT_COUNT);
	assign label_ok = (32'(class_label) < CLASS_COUNT);
	assign is_work  = (action == ACT_TRAIN) || (action == ACT_CLASSIFY);

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= LOW_THR_RESET;
			high_thr_q <= HIGH_THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LOW_THR:  low_thr_q  <= cfg_data;
				REG_HIGH_THR: high_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture, signature worked out on the way in
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q      <= action;
			sig_q      <= sig_of(pixel_a, pixel_b, pixel_c, low_thr_q, high_thr_q);
			label_q    <= class_label;
			last_q     <= last_block;
			block_ok_q <= block_ok;
			label_ok_q <= label_ok;
		end
		if (state_q == ST_KNOT) begin
			row_addr_q <= row_addr;
		end
	end

	// knot map: in-range loads write straight away, train and classify requests read the block's knot
	assign knot_cmd.rd = in_acc && is_work;
	assign knot_cmd.wr = in_acc && (action == ACT_LOAD) && block_ok && knot_ok;

	tbvc_knot_ram #(
		.DEPTH  (MAX_BLOCKS),
		.KNOT_W (KNOT_W)
	) u_knot_ram (
		.clk     (clk),
		.cmd     (knot_cmd),
		.addr    (BLK_AW'(block_index)),
		.wr_knot (KNOT_W'(knot_number)),
		.rd_knot (knot_rd)
	);

	// row address from the knot just read, out-of-range knots fold to zero
	assign knot_sel = (32'(knot_rd) < KNOT_COUNT) ? knot_rd : '0;
	assign row_addr = ROW_AW'(knot_sel) * ROW_AW'(SIG_COUNT) + ROW_AW'(sig_q);

	// count row: read in the knot cycle, written back in the modify cycle
	assign cnt_cmd.rd = (state_q == ST_KNOT);
	assign cnt_cmd.wr = (state_q == ST_MOD) && (act_q == ACT_TRAIN) && block_ok_q
		&& label_ok_q;

	// bump the lane of the training label, counts wrap
	always_comb begin
		row_wr = row_rd;
		for (int c = 0; c < CLASS_COUNT; c++) begin
			if (label_q == LABEL_W'(c)) begin
				row_wr[c*COUNT_BITS +: COUNT_BITS] =
					row_rd[c*COUNT_BITS +: COUNT_BITS] + COUNT_BITS'(1);
			end
		end
	end

	tbvc_count_mem #(
		.ROWS  (ROWS),
		.ROW_W (ROW_W)
	) u_count_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cnt_cmd),
		.rd_addr  (row_addr),
		.wr_addr  (row_addr_q),
		.wr_data  (row_wr),
		.rd_data  (row_rd),
		.clr_busy (clr_busy)
	);

	// blank signature and out-of-range blocks add nothing
	assign emit_go        = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign vote_cmd.add   = (state_q == ST_MOD) && (act_q == ACT_CLASSIFY) && block_ok_q
		&& (sig_q != SIG_W'(SIG_BLANK));
	assign vote_cmd.start = (state_q == ST_SCAN0);
	assign vote_cmd.clear = emit_go;

	tbvc_vote #(
		.CLASS_COUNT (CLASS_COUNT),
		.COUNT_BITS  (COUNT_BITS)
	) u_vote (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (vote_cmd),
		.row      (row_rd),
		.done     (scan_done),
		.best_idx (best_idx),
		.best_val (best_val)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (!clr_busy) state_d = ST_IDLE;
			ST_IDLE:  if (in_acc && is_work) state_d = ST_KNOT;
			ST_KNOT:  state_d = ST_MOD;
			ST_MOD: begin
				if ((act_q == ACT_CLASSIFY) && last_q) state_d = ST_SCAN0;
				else state_d = ST_IDLE;
			end
			ST_SCAN0: state_d = ST_SCAN;
			ST_SCAN:  if (scan_done) state_d = ST_EMIT;
			ST_EMIT:  if (emit_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// output register, freed by the downstream handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			pred_q  <= PRED_W'(best_idx);
			score_q <= SCORE_W'(best_val);
		end
	end

	assign out_valid       = out_valid_q;
	assign predicted_class = pred_q;
	assign best_score      = score_q;

	// a train or classify request walks the knot read then the row read
	a_work_path: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (action == ACT_TRAIN || action == ACT_CLASSIFY))
		|=> (state_q == ST_KNOT) ##1 (state_q == ST_MOD))
		else $error("work request left the knot and row read sequence");

	// no request is taken before the count table is cleared
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !in_ready)
		else $error("request accepted during clearing pass");

	// scan completes only while the sequencer waits for it
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> (state_q == ST_SCAN))
		else $error("argmax scan finished outside scan state");

	// a result appears only from the emit state
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside emit state");

endmodule
